>>> hdl/dmac_pkg.sv
// Shared types and constants for the DMA register block with chunk engine.
// Holds the register map, the function codes and the item/result structs.
// No dependencies.
`timescale 1ns / 1ps

package dmac_pkg;

	// Function codes carried on the input tuser
	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	// Register map (byte offsets)
	localparam logic [11:0] OFS_START    = 12'h000;
	localparam logic [11:0] OFS_CONTROL  = 12'h004;
	localparam logic [11:0] OFS_SOURCE   = 12'h008;
	localparam logic [11:0] OFS_LENGTH   = 12'h00C;
	localparam logic [11:0] OFS_DEST     = 12'h010;
	localparam logic [11:0] OFS_DEST_HI  = 12'h014;
	localparam logic [11:0] OFS_SETTINGS = 12'h018;
	localparam logic [11:0] OFS_IRQ_EN   = 12'h054;
	localparam logic [11:0] OFS_IRQ_STA  = 12'h058;

	// Reset values
	localparam logic [63:0] SOURCE_BASE_RST = 64'h0000_0000_7000_0000;
	localparam logic [31:0] CONTROL_RST     = 32'h0000_1FFF;
	localparam logic [31:0] LENGTH_RST      = 32'h0000_3FFF;

	// Status bits
	localparam int STA_DONE_BIT = 1;
	localparam int STA_PEND_BIT = 6;
	localparam logic [6:0] STA_PEND_ONLY = 7'h40;

	// Largest chunk, used when the control byte size is zero
	localparam logic [8:0] CHUNK_MAX = 9'd256;

	typedef struct packed {
		func_t       func;
		logic [11:0] reg_offset;
		logic        wide_access;
		logic [63:0] write_data;
	} item_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        irq_level;
		logic        chunk_valid;
		logic [63:0] chunk_source;
		logic [63:0] chunk_dest;
		logic [8:0]  chunk_bytes;
		logic        chunk_last;
		logic        bad_access;
	} result_t;

endpackage

>>> hdl/dmac_engine.sv
// Register file and chunk engine of the DMA block.
// Holds all architectural state; computes one result per item, combinationally.
// Depends on dmac_pkg.
`timescale 1ns / 1ps

module dmac_engine import dmac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_en,
	input  item_t       item,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	output result_t     res
);

	logic [63:0] source_base_q, nxt_source_base;
	logic [31:0] start_q, nxt_start;
	logic [31:0] control_q, nxt_control;
	logic [31:0] src_ofs_q, nxt_src_ofs;
	logic [31:0] len_q, nxt_len;
	logic [63:0] dest_q, nxt_dest;
	logic [31:0] settings_q, nxt_settings;
	logic [31:0] irq_en_q, nxt_irq_en;
	logic [6:0]  irq_sta_q, nxt_irq_sta;
	logic        busy_q, nxt_busy;
	logic [63:0] next_src_q, nxt_next_src;
	logic [63:0] next_dst_q, nxt_next_dst;
	logic [32:0] left_q, nxt_left;

	logic [31:0] wr_lo;
	logic [6:0]  sta_tog;
	logic [8:0]  limit;
	logic [8:0]  cbytes;
	logic [32:0] left_after;

	assign wr_lo = item.write_data[31:0];

	// Chunk sizing: control byte size, zero means the maximum
	always_comb begin
		limit = (control_q[7:0] == 8'd0) ? CHUNK_MAX : {1'b0, control_q[7:0]};
		cbytes = (left_q < {24'd0, limit}) ? left_q[8:0] : limit;
		left_after = left_q - {24'd0, cbytes};
		sta_tog = (irq_sta_q ^ {1'b0, item.write_data[5:0]});
	end

	// Item decode and next state
	always_comb begin
		nxt_source_base = source_base_q;
		nxt_start       = start_q;
		nxt_control     = control_q;
		nxt_src_ofs     = src_ofs_q;
		nxt_len         = len_q;
		nxt_dest        = dest_q;
		nxt_settings    = settings_q;
		nxt_irq_en      = irq_en_q;
		nxt_irq_sta     = irq_sta_q;
		nxt_busy        = busy_q;
		nxt_next_src    = next_src_q;
		nxt_next_dst    = next_dst_q;
		nxt_left        = left_q;
		res             = '0;

		case (item.func)
			FUNC_READ: begin
				case (item.reg_offset)
					OFS_START:    res.read_data = {32'd0, start_q};
					OFS_CONTROL:  res.read_data = {32'd0, control_q};
					OFS_SOURCE:   res.read_data = {32'd0, src_ofs_q};
					OFS_LENGTH:   res.read_data = {32'd0, len_q};
					OFS_DEST:     res.read_data = item.wide_access ? dest_q
						: {32'd0, dest_q[31:0]};
					OFS_DEST_HI:  res.read_data = {32'd0, dest_q[63:32]};
					OFS_SETTINGS: res.read_data = {32'd0, settings_q};
					OFS_IRQ_EN:   res.read_data = {32'd0, irq_en_q};
					OFS_IRQ_STA:  res.read_data = {57'd0, irq_sta_q};
					default:      res.bad_access = 1'b1;
				endcase
			end
			FUNC_WRITE: begin
				case (item.reg_offset)
					OFS_START: begin
						nxt_start = wr_lo;
						// bit 0 launches a transfer, dropping any running one
						if (wr_lo[0]) begin
							nxt_next_src = source_base_q + {32'd0, src_ofs_q};
							nxt_next_dst = dest_q;
							nxt_left     = {1'b0, len_q} + 33'd1;
							nxt_busy     = 1'b1;
						end
					end
					OFS_CONTROL:  nxt_control = wr_lo;
					OFS_SOURCE:   nxt_src_ofs = wr_lo;
					OFS_LENGTH:   nxt_len = wr_lo;
					OFS_DEST:     nxt_dest = item.wide_access ? item.write_data
						: {dest_q[63:32], wr_lo};
					OFS_DEST_HI:  nxt_dest = {wr_lo, dest_q[31:0]};
					OFS_SETTINGS: nxt_settings = wr_lo;
					OFS_IRQ_EN:   nxt_irq_en = wr_lo;
					OFS_IRQ_STA:  nxt_irq_sta = (sta_tog == STA_PEND_ONLY) ? 7'd0 : sta_tog;
					default:      res.bad_access = 1'b1;
				endcase
			end
			FUNC_TICK: begin
				if (busy_q) begin
					res.chunk_valid  = 1'b1;
					res.chunk_source = next_src_q;
					res.chunk_dest   = next_dst_q;
					res.chunk_bytes  = cbytes;
					nxt_next_src     = next_src_q + {55'd0, cbytes};
					nxt_next_dst     = next_dst_q + {55'd0, cbytes};
					nxt_left         = left_after;
					if (left_after == 33'd0) begin
						res.chunk_last = 1'b1;
						nxt_busy       = 1'b0;
						nxt_irq_sta[STA_DONE_BIT] = 1'b1;
						nxt_irq_sta[STA_PEND_BIT] = 1'b1;
					end
				end
			end
			default: ;
		endcase

		res.irq_level = nxt_irq_en[STA_DONE_BIT] & nxt_irq_sta[STA_PEND_BIT];

		// the user must make configuration writes only while no item is in flight; the block does not enforce this
		if (cfg_we) begin
			nxt_source_base = cfg_data;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_base_q <= SOURCE_BASE_RST;
			start_q       <= '0;
			control_q     <= CONTROL_RST;
			src_ofs_q     <= '0;
			len_q         <= LENGTH_RST;
			dest_q        <= '0;
			settings_q    <= '0;
			irq_en_q      <= '0;
			irq_sta_q     <= '0;
			busy_q        <= 1'b0;
			next_src_q    <= '0;
			next_dst_q    <= '0;
			left_q        <= '0;
		end else begin
			source_base_q <= nxt_source_base;
			if (item_en) begin
				start_q    <= nxt_start;
				control_q  <= nxt_control;
				src_ofs_q  <= nxt_src_ofs;
				len_q      <= nxt_len;
				dest_q     <= nxt_dest;
				settings_q <= nxt_settings;
				irq_en_q   <= nxt_irq_en;
				irq_sta_q  <= nxt_irq_sta;
				busy_q     <= nxt_busy;
				next_src_q <= nxt_next_src;
				next_dst_q <= nxt_next_dst;
				left_q     <= nxt_left;
			end
		end
	end

`ifndef ASSERT_OFF
	a_chunk_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && res.chunk_valid |-> busy_q)
		else $error("chunk issued with no transfer running");

	a_chunk_size: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && res.chunk_valid |-> (res.chunk_bytes != 9'd0) &&
		(res.chunk_bytes <= CHUNK_MAX) && ({24'd0, res.chunk_bytes} <= left_q))
		else $error("chunk size out of range");

	a_last_ends_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		item_en && res.chunk_last |=> !busy_q && irq_sta_q[STA_PEND_BIT] &&
		(left_q == 33'd0))
		else $error("final chunk did not close the transfer");

	a_busy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != 33'd0)
		else $error("transfer running with nothing left");
`endif

endmodule

>>> hdl/dma_register_block_with_chunker.sv
// Top level of the DMA register block with chunk engine.
// Input register, the dmac_engine and the output register.
// Depends on dmac_pkg and dmac_engine.
`timescale 1ns / 1ps

// Usage:
// Items enter on the s_axis channel: tuser is the function (read, write,
// tick), tdata the offset, access width and write data. Every item gives
// exactly one result beat on m_axis: read data, interrupt level, bad
// access flag and, for a tick during a transfer, one copy chunk with its
// source, destination and byte count; tlast marks the final chunk.
// The source base register is written on the cfg channel (always ready); the
// user must write it only while no item is in flight, the block does not enforce this.
// A result beat passes through the input register and then the output register
// before it is presented; a stall on m_axis can hold it in either register.
// One item per cycle is sustained while m_axis does not stall; all decode and
// state update for an item is done combinationally between the two registers.
// When m_axis stalls, the held result stays in the output register and one
// more item is still taken into the input register; tready drops only when
// both are full.
// Reset (arst_n low) empties both registers and returns all engine registers to
// their reset values, with no transfer running.

module dma_register_block_with_chunker import dmac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// cfg: source base address
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [63:0]  cfg_data,
	// input items
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // reg_offset[11:0], wide_access[12], write_data[76:13]
	input  logic [1:0]   s_axis_tuser,  // func[1:0]
	// results
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [207:0] m_axis_tdata,  // read_data[63:0], irq_level[64], chunk_valid[65],
	                                    // chunk_source[129:66], chunk_dest[193:130],
	                                    // chunk_bytes[202:194], bad_access[203]
	output logic         m_axis_tlast   // chunk_last
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    out_ready;
	logic    adv_s1;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_ready;
	assign s_axis_tready = !valid_s1 || out_ready;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.func        <= func_t'(s_axis_tuser);
			item_s1.reg_offset  <= s_axis_tdata[11:0];
			item_s1.wide_access <= s_axis_tdata[12];
			item_s1.write_data  <= s_axis_tdata[76:13];
		end
	end

	dmac_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_en  (adv_s1),
		.item     (item_s1),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.res      (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = res_q.chunk_last;
	assign m_axis_tdata  = {4'd0, res_q.bad_access, res_q.chunk_bytes, res_q.chunk_dest,
		res_q.chunk_source, res_q.chunk_valid, res_q.irq_level, res_q.read_data};

endmodule

>>> bench/tb_dma_register_block_with_chunker.sv
// Testbench for dma_register_block_with_chunker: register accesses, copy starts and ticks
// are checked beat by beat against a behavioral copy of the register block and chunk engine.
// Depends on dmac_pkg and the dma_register_block_with_chunker RTL.
`timescale 1ns / 1ps

module tb_dma_register_block_with_chunker;
	import dmac_pkg::*;

	localparam func_t FUNC_UNUSED = func_t'(2'd3);
	localparam logic [11:0] OFS_NONE_HI = 12'hFFF;
	localparam logic [11:0] OFS_NONE_GAP = 12'h01C;
	localparam int PHASE_ITEMS = 145;
	localparam int HOLD_CYCLES = 60;
	localparam int HOLD_AFTER = 100;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [63:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [207:0] m_axis_tdata;
	logic m_axis_tlast;

	dma_register_block_with_chunker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the register file and copy engine
	logic [63:0] base_addr = SOURCE_BASE_RST;
	logic [31:0] start_reg = '0;
	logic [31:0] ctrl_reg = CONTROL_RST;
	logic [31:0] src_ofs_reg = '0;
	logic [31:0] len_m1_reg = LENGTH_RST;
	logic [63:0] dst_reg = '0;
	logic [31:0] settings_reg = '0;
	logic [31:0] irq_en_reg = '0;
	logic [6:0] sta_reg = '0;
	logic copy_active = 1'b0;
	logic [63:0] cur_src = '0;
	logic [63:0] cur_dst = '0;
	logic [32:0] remaining = '0;

	item_t pending_items[$];
	result_t due_results[$];
	int queued_items = 0;
	int results_seen = 0;
	int errors = 0;
	int cycles = 0;
	bit src_quiet = 1'b0;
	bit snk_quiet = 1'b0;
	bit hold_active = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	// Apply one item to the shadow registers, return the beat it should produce
	function automatic result_t dma_step(item_t it);
		result_t r;
		logic [31:0] lo;
		logic [32:0] limit;
		logic [32:0] take;
		r = '0;
		lo = it.write_data[31:0];
		case (it.func)
			FUNC_READ: begin
				case (it.reg_offset)
					OFS_START:    r.read_data = {32'b0, start_reg};
					OFS_CONTROL:  r.read_data = {32'b0, ctrl_reg};
					OFS_SOURCE:   r.read_data = {32'b0, src_ofs_reg};
					OFS_LENGTH:   r.read_data = {32'b0, len_m1_reg};
					OFS_DEST:     r.read_data = it.wide_access ? dst_reg : {32'b0, dst_reg[31:0]};
					OFS_DEST_HI:  r.read_data = {32'b0, dst_reg[63:32]};
					OFS_SETTINGS: r.read_data = {32'b0, settings_reg};
					OFS_IRQ_EN:   r.read_data = {32'b0, irq_en_reg};
					OFS_IRQ_STA:  r.read_data = {57'b0, sta_reg};
					default:      r.bad_access = 1'b1;
				endcase
			end
			FUNC_WRITE: begin
				case (it.reg_offset)
					OFS_START: begin
						start_reg = lo;
						if (lo[0]) begin
							cur_src = base_addr + {32'b0, src_ofs_reg};
							cur_dst = dst_reg;
							remaining = {1'b0, len_m1_reg} + 33'd1;
							copy_active = 1'b1;
						end
					end
					OFS_CONTROL:  ctrl_reg = lo;
					OFS_SOURCE:   src_ofs_reg = lo;
					OFS_LENGTH:   len_m1_reg = lo;
					OFS_DEST:     dst_reg = it.wide_access ? it.write_data : {dst_reg[63:32], lo};
					OFS_DEST_HI:  dst_reg = {lo, dst_reg[31:0]};
					OFS_SETTINGS: settings_reg = lo;
					OFS_IRQ_EN:   irq_en_reg = lo;
					OFS_IRQ_STA: begin
						// toggle the low six bits; a lone pending bit clears itself
						sta_reg = sta_reg ^ {1'b0, it.write_data[5:0]};
						if (sta_reg == STA_PEND_ONLY)
							sta_reg = '0;
					end
					default:      r.bad_access = 1'b1;
				endcase
			end
			FUNC_TICK: begin
				if (copy_active) begin
					limit = (ctrl_reg[7:0] == 8'd0) ? {24'b0, CHUNK_MAX} : {25'b0, ctrl_reg[7:0]};
					take = (remaining < limit) ? remaining : limit;
					r.chunk_valid = 1'b1;
					r.chunk_source = cur_src;
					r.chunk_dest = cur_dst;
					r.chunk_bytes = take[8:0];
					cur_src = cur_src + {31'b0, take};
					cur_dst = cur_dst + {31'b0, take};
					remaining = remaining - take;
					if (remaining == '0) begin
						r.chunk_last = 1'b1;
						copy_active = 1'b0;
						sta_reg[STA_DONE_BIT] = 1'b1;
						sta_reg[STA_PEND_BIT] = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.irq_level = irq_en_reg[STA_DONE_BIT] & sta_reg[STA_PEND_BIT];
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_item(func_t f, logic [11:0] ofs, logic wide, logic [63:0] data);
		item_t it;
		it.func = f;
		it.reg_offset = ofs;
		it.wide_access = wide;
		it.write_data = data;
		pending_items.push_back(it);
		queued_items++;
	endtask

	function automatic logic [11:0] pick_offset();
		logic [11:0] known[9];
		known = '{OFS_START, OFS_CONTROL, OFS_SOURCE, OFS_LENGTH, OFS_DEST,
			OFS_DEST_HI, OFS_SETTINGS, OFS_IRQ_EN, OFS_IRQ_STA};
		if ($urandom_range(0, 3) == 0)
			return 12'($urandom);
		return known[$urandom_range(0, 8)];
	endfunction

	// Program a copy, start it, tick it along and service the interrupt status
	task automatic queue_copy_run();
		logic [7:0] chunk_sz;
		logic [31:0] len;
		logic [63:0] go;
		int n_ticks;
		chunk_sz = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
		if ($urandom_range(0, 9) == 0)
			chunk_sz = 8'd0;
		add_item(FUNC_WRITE, OFS_CONTROL, 1'($urandom), {56'(rand64() >> 8), chunk_sz});
		if ($urandom_range(0, 1))
			add_item(FUNC_WRITE, OFS_SOURCE, 1'($urandom), rand64());
		case ($urandom_range(0, 9))
			0: len = $urandom;
			1: len = '0;
			default: len = $urandom_range(0, 60);
		endcase
		add_item(FUNC_WRITE, OFS_LENGTH, 1'($urandom), {$urandom, len});
		if ($urandom_range(0, 1)) begin
			add_item(FUNC_WRITE, OFS_DEST, 1'b1, rand64());
		end else begin
			add_item(FUNC_WRITE, OFS_DEST_HI, 1'($urandom), rand64());
			add_item(FUNC_WRITE, OFS_DEST, 1'b0, rand64());
		end
		if ($urandom_range(0, 2) == 0)
			add_item(FUNC_WRITE, OFS_IRQ_EN, 1'($urandom), rand64());
		if ($urandom_range(0, 4) == 0)
			add_item(FUNC_WRITE, OFS_SETTINGS, 1'($urandom), rand64());
		go = rand64();
		go[0] = ($urandom_range(0, 9) != 0);
		add_item(FUNC_WRITE, OFS_START, 1'($urandom), go);
		n_ticks = $urandom_range(1, 10);
		repeat (n_ticks) begin
			if ($urandom_range(0, 4) == 0)
				add_item(FUNC_READ, pick_offset(), 1'($urandom), rand64());
			add_item(FUNC_TICK, 12'($urandom), 1'($urandom), rand64());
		end
		add_item(FUNC_READ, OFS_IRQ_STA, 1'($urandom), rand64());
		if ($urandom_range(0, 2) == 0)
			add_item(FUNC_WRITE, OFS_IRQ_STA, 1'($urandom), rand64());
		else
			add_item(FUNC_WRITE, OFS_IRQ_STA, 1'($urandom), 64'h2);
	endtask

	task automatic queue_noise();
		func_t f;
		f = ($urandom_range(0, 9) == 0) ? FUNC_UNUSED : func_t'($urandom_range(0, 2));
		add_item(f, pick_offset(), 1'($urandom), rand64());
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_source_base(logic [63:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
			errors++;
		end
	endtask

	// Input driver: one beat per queued item, random gap after each
	int src_gap = 0;
	int src_sent = 0;
	always @(posedge clk or negedge arst_n) begin
		item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				s_axis_tdata <= {3'b0, it.write_data, it.wide_access, it.reg_offset};
				s_axis_tuser <= it.func;
				s_axis_tvalid <= 1'b1;
				src_sent++;
				if (src_sent % 40 == 0)
					src_quiet = ($urandom_range(0, 3) == 0);
				src_gap = src_quiet ? 0 : $urandom_range(0, 3);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, once, to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && !hold_active && results_seen >= HOLD_AFTER) begin
			hold_active <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_active) begin
			if (hold_left == 0) begin
				hold_active <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// Result receiver: random stall after each beat
	int snk_stall = 0;
	int snk_taken = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				snk_taken++;
				if (snk_taken % 40 == 0)
					snk_quiet = ($urandom_range(0, 3) == 0);
				snk_stall = snk_quiet ? 0 : $urandom_range(0, 3);
			end
			if (hold_active) begin
				m_axis_tready <= 1'b0;
			end else if (snk_stall > 0) begin
				snk_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Predict on accepted input beats, check accepted result beats
	always @(posedge clk) begin
		item_t it;
		result_t want;
		result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				base_addr = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				it.func = func_t'(s_axis_tuser);
				it.reg_offset = s_axis_tdata[11:0];
				it.wide_access = s_axis_tdata[12];
				it.write_data = s_axis_tdata[76:13];
				due_results.push_back(dma_step(it));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.read_data = m_axis_tdata[63:0];
				got.irq_level = m_axis_tdata[64];
				got.chunk_valid = m_axis_tdata[65];
				got.chunk_source = m_axis_tdata[129:66];
				got.chunk_dest = m_axis_tdata[193:130];
				got.chunk_bytes = m_axis_tdata[202:194];
				got.chunk_last = m_axis_tlast;
				got.bad_access = m_axis_tdata[203];
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want = due_results.pop_front();
					compare_field("read_data", want.read_data, got.read_data);
					compare_field("irq_level", 64'(want.irq_level), 64'(got.irq_level));
					compare_field("chunk_valid", 64'(want.chunk_valid), 64'(got.chunk_valid));
					compare_field("chunk_source", want.chunk_source, got.chunk_source);
					compare_field("chunk_dest", want.chunk_dest, got.chunk_dest);
					compare_field("chunk_bytes", 64'(want.chunk_bytes), 64'(got.chunk_bytes));
					compare_field("chunk_last", 64'(want.chunk_last), 64'(got.chunk_last));
					compare_field("bad_access", 64'(want.bad_access), 64'(got.bad_access));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [63:0] bases[4];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, wide/narrow halves, chunk size zero, restart
		// while busy, writes during a copy, status toggling, bad offsets
		add_item(FUNC_READ, OFS_CONTROL, 1'b0, '0);
		add_item(FUNC_WRITE, OFS_CONTROL, 1'b1, 64'hA5A5_A5A5_FFFF_FF00);
		add_item(FUNC_WRITE, OFS_LENGTH, 1'b0, 64'h0000_0000_0000_0200);
		add_item(FUNC_WRITE, OFS_SOURCE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FUNC_WRITE, OFS_DEST_HI, 1'b0, 64'hDEAD_BEEF_1234_5678);
		add_item(FUNC_WRITE, OFS_DEST, 1'b0, 64'hFFFF_FFFF_9ABC_DEF0);
		add_item(FUNC_READ, OFS_DEST, 1'b1, '0);
		add_item(FUNC_WRITE, OFS_DEST, 1'b1, 64'hFFFF_FFFF_FFFF_FF80);
		add_item(FUNC_WRITE, OFS_IRQ_EN, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FUNC_WRITE, OFS_START, 1'b0, 64'h1);
		add_item(FUNC_TICK, 12'h000, 1'b0, '0);
		add_item(FUNC_WRITE, OFS_SOURCE, 1'b0, '0);
		add_item(FUNC_TICK, 12'hFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FUNC_WRITE, OFS_START, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		repeat (4) add_item(FUNC_TICK, 12'h000, 1'b0, '0);
		add_item(FUNC_READ, OFS_IRQ_STA, 1'b0, '0);
		add_item(FUNC_WRITE, OFS_IRQ_STA, 1'b0, 64'h2);
		add_item(FUNC_WRITE, OFS_IRQ_STA, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FUNC_READ, OFS_NONE_HI, 1'b1, '0);
		add_item(FUNC_WRITE, OFS_NONE_GAP, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FUNC_UNUSED, OFS_START, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		// Random phases, each with its own source base
		bases = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, rand64(), rand64()};
		foreach (bases[p]) begin
			write_source_base(bases[p]);
			queued_items = 0;
			while (queued_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					queue_copy_run();
				else
					repeat ($urandom_range(1, 4)) queue_noise();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> dma_register_block_with_chunker.f
hdl/dmac_pkg.sv
hdl/dmac_engine.sv
hdl/dma_register_block_with_chunker.sv
bench/tb_dma_register_block_with_chunker.sv
